/* rtl/jet_pkg.sv */
package jet_pkg;

    // fixed widths of the external fields
    localparam int COORD_PORT_BITS = 32;
    localparam int CFG_DATA_BITS   = 32;
    localparam int RADIUS_BITS     = 31;
    localparam int ITER_LIMIT_BITS = 8;
    localparam int COUNT_BITS      = 9;
    localparam int SHADE_BITS      = 11;

    // digit width of one multiplier cell
    localparam int DIGIT_BITS = 16;

    // gray step per iteration
    localparam logic [SHADE_BITS-1:0] SHADE_STEP = 11'd5;

    // register reset values
    localparam logic [CFG_DATA_BITS-1:0]   C_RE_RESET       = 32'hFD00_0000;
    localparam logic [CFG_DATA_BITS-1:0]   C_IM_RESET       = 32'h000A_3D71;
    localparam logic [RADIUS_BITS-1:0]     RADIUS_RESET     = 31'd151001648;
    localparam logic [ITER_LIMIT_BITS-1:0] ITER_LIMIT_RESET = 8'd51;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_C_RE       = 2'd0,
        REG_C_IM       = 2'd1,
        REG_RADIUS     = 2'd2,
        REG_ITER_LIMIT = 2'd3
    } t_cfg_reg;

endpackage

/* rtl/jet_cell.sv */
module jet_cell #(
    parameter int W    = 32,
    parameter int NDIG = 2,
    parameter int K    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_x,
    input  logic signed [W-1:0]   i_y,
    input  logic signed [2*W-1:0] i_acc_xx,
    input  logic signed [2*W-1:0] i_acc_yy,
    input  logic signed [2*W-1:0] i_acc_xy,
    output logic                  o_valid,
    output logic signed [W-1:0]   o_x,
    output logic signed [W-1:0]   o_y,
    output logic signed [2*W-1:0] o_acc_xx,
    output logic signed [2*W-1:0] o_acc_yy,
    output logic signed [2*W-1:0] o_acc_xy
);

    localparam int DB   = jet_pkg::DIGIT_BITS;
    localparam int PADW = NDIG * DB;
    localparam int PW   = 2 * W;
    localparam bit TOP  = (K == NDIG - 1);

    logic signed [PADW-1:0] x_pad;
    logic signed [PADW-1:0] y_pad;
    logic        [DB-1:0]   x_dig;
    logic        [DB-1:0]   y_dig;
    logic signed [DB:0]     dx;
    logic signed [DB:0]     dy;
    logic signed [W+DB:0]   p_xx;
    logic signed [W+DB:0]   p_yy;
    logic signed [W+DB:0]   p_xy;

    logic                   r_valid;
    logic signed [W-1:0]    r_x;
    logic signed [W-1:0]    r_y;
    logic signed [PW-1:0]   r_acc_xx;
    logic signed [PW-1:0]   r_acc_yy;
    logic signed [PW-1:0]   r_acc_xy;

    // pick this cell's digit; only the top digit carries the sign
    always_comb begin
        x_pad = PADW'(i_x);
        y_pad = PADW'(i_y);
        x_dig = x_pad[K*DB +: DB];
        y_dig = y_pad[K*DB +: DB];
        dx    = TOP ? $signed({x_dig[DB-1], x_dig}) : $signed({1'b0, x_dig});
        dy    = TOP ? $signed({y_dig[DB-1], y_dig}) : $signed({1'b0, y_dig});
        p_xx  = i_x * dx;
        p_yy  = i_y * dy;
        p_xy  = i_x * dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_x      <= i_x;
        r_y      <= i_y;
        r_acc_xx <= i_acc_xx + (PW'(p_xx) <<< (K * DB));
        r_acc_yy <= i_acc_yy + (PW'(p_yy) <<< (K * DB));
        r_acc_xy <= i_acc_xy + (PW'(p_xy) <<< (K * DB));
    end

    assign o_valid  = r_valid;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_acc_xx = r_acc_xx;
    assign o_acc_yy = r_acc_yy;
    assign o_acc_xy = r_acc_xy;

endmodule

/* rtl/julia_escape_time.sv */
// Julia-set escape-time engine. One beat on start carries a pixel's starting
// point z0 in signed fixed point (COORD_WIDTH bits, FRAC_BITS fraction bits);
// the engine iterates z = z*z + c and returns one result beat: the number of
// iterations before |z|^2 exceeded escape_radius_sq, or the iteration limit plus
// one when it never did, together with a gray shade of five times that count.
// Each product is a full-width sum of partial products formed in a row of
// NDIG = ceil(COORD_WIDTH/16) digit cells; the operands walk through the row,
// one register per cell, and one update register closes the loop. o_busy is high
// while a pixel is in flight; a new start is taken in the same cycle that the
// result strobe o_valid is shown. The result is on the output ports for one
// cycle only and cannot be held off. Configuration must be written only while
// o_busy is low; the user is bound to this, the block itself does not enforce
// it. c and coordinates wider than COORD_WIDTH are saturated to its range.
module julia_escape_time #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item channel
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [jet_pkg::COORD_PORT_BITS-1:0]    i_start_re,
    input  logic [jet_pkg::COORD_PORT_BITS-1:0]    i_start_im,
    // result channel
    output logic                                   o_valid,
    output logic [jet_pkg::COUNT_BITS-1:0]         o_iteration_count,
    output logic [jet_pkg::SHADE_BITS-1:0]         o_shade,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_addr,
    input  logic [jet_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int NDIG = (W + jet_pkg::DIGIT_BITS - 1) / jet_pkg::DIGIT_BITS;
    // width that holds |z|^2, the shifted radius and all update sums
    localparam int SW   = (2 * W + 2 > jet_pkg::RADIUS_BITS + F + 1)
                          ? 2 * W + 2 : jet_pkg::RADIUS_BITS + F + 1;
    localparam int PB   = jet_pkg::COORD_PORT_BITS;
    localparam int EW   = (W > PB) ? W + 1 : PB + 1;

    // configuration registers
    logic [jet_pkg::CFG_DATA_BITS-1:0]   r_c_re;
    logic [jet_pkg::CFG_DATA_BITS-1:0]   r_c_im;
    logic [jet_pkg::RADIUS_BITS-1:0]     r_radius;
    logic [jet_pkg::ITER_LIMIT_BITS-1:0] r_iter_limit;

    // loop control and operands
    logic                               r_busy;
    logic                               r_launch;
    logic [jet_pkg::COUNT_BITS-1:0]     r_count;
    logic signed [W-1:0]                r_x;
    logic signed [W-1:0]                r_y;
    logic signed [W-1:0]                r_cr;
    logic signed [W-1:0]                r_ci;

    // result register
    logic                               r_valid;
    logic [jet_pkg::COUNT_BITS-1:0]     r_res_count;
    logic [jet_pkg::SHADE_BITS-1:0]     r_res_shade;

    // cell row taps
    logic                               s_valid  [NDIG+1];
    logic signed [W-1:0]                s_x      [NDIG+1];
    logic signed [W-1:0]                s_y      [NDIG+1];
    logic signed [PW-1:0]               s_acc_xx [NDIG+1];
    logic signed [PW-1:0]               s_acc_yy [NDIG+1];
    logic signed [PW-1:0]               s_acc_xy [NDIG+1];

    // update path
    logic signed [SW-1:0]               mag;
    logic signed [SW-1:0]               bound;
    logic signed [SW-1:0]               nx_full;
    logic signed [SW-1:0]               ny_full;
    logic signed [W-1:0]                n_x;
    logic signed [W-1:0]                n_y;
    logic                               escaped;
    logic                               at_limit;
    logic                               accept;

    // saturate a 32 bit port value to the coordinate range
    function automatic logic signed [W-1:0] f_clamp_port(input logic signed [PB-1:0] v);
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        e  = EW'(v);
        hi = $signed({{(EW-W+1){1'b0}}, {(W-1){1'b1}}});
        lo = ~hi;
        if (e > hi) begin
            return hi[W-1:0];
        end else if (e < lo) begin
            return lo[W-1:0];
        end
        return e[W-1:0];
    endfunction

    // saturate a wide update sum to the coordinate range
    function automatic logic signed [W-1:0] f_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[W-1:0];
        end else if (v < lo) begin
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    assign accept = i_start && !r_busy;

    // head of the cell row: fresh operands, empty accumulators
    assign s_valid[0]  = r_launch;
    assign s_x[0]      = r_x;
    assign s_y[0]      = r_y;
    assign s_acc_xx[0] = '0;
    assign s_acc_yy[0] = '0;
    assign s_acc_xy[0] = '0;

    // one digit of each multiplier per cell, partial sums handed down the row
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        jet_cell #(
            .W    (W),
            .NDIG (NDIG),
            .K    (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (s_valid[k]),
            .i_x      (s_x[k]),
            .i_y      (s_y[k]),
            .i_acc_xx (s_acc_xx[k]),
            .i_acc_yy (s_acc_yy[k]),
            .i_acc_xy (s_acc_xy[k]),
            .o_valid  (s_valid[k+1]),
            .o_x      (s_x[k+1]),
            .o_y      (s_y[k+1]),
            .o_acc_xx (s_acc_xx[k+1]),
            .o_acc_yy (s_acc_yy[k+1]),
            .o_acc_xy (s_acc_xy[k+1])
        );
    end

    // escape test and next z from the finished products
    always_comb begin
        mag      = SW'(s_acc_xx[NDIG]) + SW'(s_acc_yy[NDIG]);
        bound    = $signed(SW'(r_radius) << F);
        escaped  = bound < mag;
        at_limit = r_count > jet_pkg::COUNT_BITS'(r_iter_limit);
        // floor shift of the exact sums, then the constant term
        nx_full  = ((SW'(s_acc_xx[NDIG]) - SW'(s_acc_yy[NDIG])) >>> F) + SW'(r_cr);
        ny_full  = ((SW'(s_acc_xy[NDIG]) <<< 1) >>> F) + SW'(r_ci);
        n_x      = f_sat(nx_full);
        n_y      = f_sat(ny_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_re       <= jet_pkg::C_RE_RESET;
            r_c_im       <= jet_pkg::C_IM_RESET;
            r_radius     <= jet_pkg::RADIUS_RESET;
            r_iter_limit <= jet_pkg::ITER_LIMIT_RESET;
            r_busy       <= 1'b0;
            r_launch     <= 1'b0;
            r_valid      <= 1'b0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (jet_pkg::t_cfg_reg'(i_cfg_addr))
                    jet_pkg::REG_C_RE: begin
                        r_c_re <= i_cfg_data;
                    end
                    jet_pkg::REG_C_IM: begin
                        r_c_im <= i_cfg_data;
                    end
                    jet_pkg::REG_RADIUS: begin
                        r_radius <= i_cfg_data[jet_pkg::RADIUS_BITS-1:0];
                    end
                    jet_pkg::REG_ITER_LIMIT: begin
                        r_iter_limit <= i_cfg_data[jet_pkg::ITER_LIMIT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                // new pixel: load z0 and c, start the first pass
                r_busy   <= 1'b1;
                r_launch <= 1'b1;
                r_valid  <= 1'b0;
                r_count  <= '0;
            end else if (r_busy && s_valid[NDIG]) begin
                if (at_limit || escaped) begin
                    // result beat
                    r_busy   <= 1'b0;
                    r_launch <= 1'b0;
                    r_valid  <= 1'b1;
                end else begin
                    r_launch <= 1'b1;
                    r_valid  <= 1'b0;
                    r_count  <= r_count + 1'b1;
                end
            end else begin
                r_launch <= 1'b0;
                r_valid  <= 1'b0;
            end
        end

        // operand and result payload
        if (accept) begin
            r_x  <= f_clamp_port($signed(i_start_re));
            r_y  <= f_clamp_port($signed(i_start_im));
            r_cr <= f_clamp_port($signed(r_c_re));
            r_ci <= f_clamp_port($signed(r_c_im));
        end else if (r_busy && s_valid[NDIG]) begin
            r_x <= n_x;
            r_y <= n_y;
        end
        r_res_count <= r_count;
        r_res_shade <= jet_pkg::SHADE_STEP * jet_pkg::SHADE_BITS'(r_count);
    end

    assign o_busy            = r_busy;
    assign o_valid           = r_valid;
    assign o_iteration_count = r_res_count;
    assign o_shade           = r_res_shade;

endmodule

/* tb/julia_escape_time_checker.sv */
module julia_escape_time_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 26
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [jet_pkg::COORD_PORT_BITS-1:0] i_start_re,
    input  logic [jet_pkg::COORD_PORT_BITS-1:0] i_start_im,
    input  logic                                i_valid,
    input  logic [jet_pkg::COUNT_BITS-1:0]      i_iteration_count,
    input  logic [jet_pkg::SHADE_BITS-1:0]      i_shade,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [jet_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [jet_pkg::COUNT_BITS-1:0] count;
        logic [jet_pkg::SHADE_BITS-1:0] shade;
    } t_pixel_result;

    localparam t_wide COORD_MAX = (t_wide'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam t_wide COORD_MIN = -COORD_MAX - 1;

    // shadow copy of the register file
    logic signed [jet_pkg::CFG_DATA_BITS-1:0] julia_c_re;
    logic signed [jet_pkg::CFG_DATA_BITS-1:0] julia_c_im;
    logic [jet_pkg::RADIUS_BITS-1:0]          radius_sq;
    logic [jet_pkg::ITER_LIMIT_BITS-1:0]      iter_limit;

    t_pixel_result expected_pixels[$];

    function automatic t_wide clamp_coord(input t_wide v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // walk the orbit of one starting point and count the steps that stay inside
    function automatic t_pixel_result escape_time(input logic signed [31:0] re,
                                                  input logic signed [31:0] im);
        t_wide x, y, cr, ci, bound, xx, yy, nx, ny;
        int unsigned steps;
        t_pixel_result r;
        x     = clamp_coord(t_wide'(re));
        y     = clamp_coord(t_wide'(im));
        cr    = clamp_coord(t_wide'(julia_c_re));
        ci    = clamp_coord(t_wide'(julia_c_im));
        bound = t_wide'({1'b0, radius_sq}) <<< FRAC_BITS;
        steps = 0;
        while (steps <= iter_limit) begin
            xx = x * x;
            yy = y * y;
            if (xx + yy > bound) break;
            nx = ((xx - yy) >>> FRAC_BITS) + cr;
            ny = (((x * y) <<< 1) >>> FRAC_BITS) + ci;
            x  = clamp_coord(nx);
            y  = clamp_coord(ny);
            steps++;
        end
        r.count = jet_pkg::COUNT_BITS'(steps);
        r.shade = jet_pkg::SHADE_BITS'(steps * 5);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            julia_c_re = jet_pkg::C_RE_RESET;
            julia_c_im = jet_pkg::C_IM_RESET;
            radius_sq  = jet_pkg::RADIUS_RESET;
            iter_limit = jet_pkg::ITER_LIMIT_RESET;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (jet_pkg::t_cfg_reg'(i_cfg_addr))
                    jet_pkg::REG_C_RE:       julia_c_re = i_cfg_data;
                    jet_pkg::REG_C_IM:       julia_c_im = i_cfg_data;
                    jet_pkg::REG_RADIUS:     radius_sq  = i_cfg_data[jet_pkg::RADIUS_BITS-1:0];
                    jet_pkg::REG_ITER_LIMIT: iter_limit =
                                                 i_cfg_data[jet_pkg::ITER_LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
            // the result beat retires before a start beat of the same edge
            if (i_valid) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result count %0d shade %0d with no pixel waiting",
                                              i_iteration_count, i_shade));
                end else begin
                    want = expected_pixels.pop_front();
                    o_checked++;
                    if (i_iteration_count !== want.count)
                        report_mismatch($sformatf("iteration_count expected %0d got %0d",
                                                  want.count, i_iteration_count));
                    if (i_shade !== want.shade)
                        report_mismatch($sformatf("shade expected %0d got %0d",
                                                  want.shade, i_shade));
                end
            end
            if (i_start && !i_busy)
                expected_pixels.push_back(escape_time(i_start_re, i_start_im));
        end
        o_pending <= expected_pixels.size();
    end

endmodule

/* tb/julia_escape_time_test.sv */
module julia_escape_time_test;
    timeunit 1ns;
    timeprecision 1ps;

    // longest quiet stretch, well above a non-escaping pixel at limit 255
    localparam int QUIET_LIMIT  = 4000;
    // drain time after the last result, about one full-length pixel
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_PHASES = 11;

    // q6.26 landmarks
    localparam logic [31:0] ONE       = 32'h0400_0000;
    localparam logic [31:0] THREE     = 32'h0C00_0000;
    localparam logic [31:0] FOUR      = 32'h1000_0000;
    localparam logic [31:0] FIVE      = 32'h1400_0000;
    localparam logic [31:0] NEAR_4    = 32'h0F99_9999;
    localparam logic [31:0] NEG_4     = 32'hF066_6667;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX   = 32'h8000_0000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_start;
    logic                                o_busy;
    logic [jet_pkg::COORD_PORT_BITS-1:0] i_start_re;
    logic [jet_pkg::COORD_PORT_BITS-1:0] i_start_im;
    logic                                o_valid;
    logic [jet_pkg::COUNT_BITS-1:0]      o_iteration_count;
    logic [jet_pkg::SHADE_BITS-1:0]      o_shade;
    logic                                i_cfg_we;
    logic [1:0]                          i_cfg_addr;
    logic [jet_pkg::CFG_DATA_BITS-1:0]   i_cfg_data;

    int errors;
    int pending;
    int checked;
    int pixels_sent;
    int settings_used;
    int quiet_cycles;
    bit steady;     // no idle cycles on the start side while set

    julia_escape_time dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_start_re        (i_start_re),
        .i_start_im        (i_start_im),
        .o_valid           (o_valid),
        .o_iteration_count (o_iteration_count),
        .o_shade           (o_shade),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data)
    );

    julia_escape_time_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_start_re        (i_start_re),
        .i_start_im        (i_start_im),
        .i_valid           (o_valid),
        .i_iteration_count (o_iteration_count),
        .i_shade           (o_shade),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: any start beat or result beat restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("julia_escape_time_test failed");
                $finish;
            end
        end
    end

    // offer one pixel; start drops on random idle cycles while waiting, so the
    // beat lands either right on the result cycle or on a later one
    task automatic send_pixel(input logic [31:0] re, input logic [31:0] im);
        bit idle;
        i_start_re <= re;
        i_start_im <= im;
        forever begin
            idle = !steady && ($urandom_range(0, 99) < 31);
            i_start <= !idle;
            @(posedge i_clk);
            if (!idle && !o_busy) break;
        end
        pixels_sent++;
    endtask

    // hold off until every pixel has come back, so the engine is idle
    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // write all four registers back to back, engine idle
    task automatic program_regs(input logic [31:0] c_re, input logic [31:0] c_im,
                                input logic [31:0] radius, input logic [31:0] limit);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= jet_pkg::REG_C_RE;
        i_cfg_data <= c_re;
        @(posedge i_clk);
        i_cfg_addr <= jet_pkg::REG_C_IM;
        i_cfg_data <= c_im;
        @(posedge i_clk);
        i_cfg_addr <= jet_pkg::REG_RADIUS;
        i_cfg_data <= radius;
        @(posedge i_clk);
        i_cfg_addr <= jet_pkg::REG_ITER_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // mostly points in the |re|, |im| <= 2 square, some anywhere, some at the rails
    function automatic logic [31:0] pick_coord();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 70) return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        if (k < 85) return $urandom();
        case ($urandom_range(0, 5))
            0: return NEG_MAX;
            1: return POS_MAX;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return ONE;
        endcase
    endfunction

    // julia constant: usually the interesting |re|, |im| <= 1 square, sometimes any value
    function automatic logic [31:0] pick_constant();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endfunction

    initial begin
        logic [31:0] radius_word;
        logic [31:0] limit_word;
        int          n_items;

        // every input known from time zero
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_start_re <= '0;
        i_start_im <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= jet_pkg::REG_C_RE;
        i_cfg_data <= '0;
        steady     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset constant c = -0.75 + 0.01i, radius 1.5, limit 51
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(POS_MAX, POS_MAX);           // far outside, zero count
        send_pixel(NEG_MAX, NEG_MAX);
        send_pixel(NEG_MAX, POS_MAX);
        send_pixel(POS_MAX, 32'h0000_0000);
        send_pixel(32'h0000_0000, NEG_MAX);
        send_pixel(ONE, 32'h0000_0000);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0001);
        send_pixel(THREE, 32'h0000_0000);

        // c at the positive rail, widest radius: new coordinates saturate high
        program_regs(POS_MAX, POS_MAX, POS_MAX, 32'd255);
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(FIVE, 32'h0000_0000);
        send_pixel(32'h0000_0000, FIVE);
        send_pixel(NEAR_4, NEAR_4);

        // c at the negative rail: saturation toward the low limit
        program_regs(NEG_MAX, NEG_MAX, POS_MAX, 32'd255);
        send_pixel(FIVE, 32'h0000_0000);
        send_pixel(32'h0000_0000, FIVE);
        send_pixel(NEG_4, NEAR_4);
        send_pixel(NEAR_4, NEAR_4);

        // zero radius: only the origin stays in, and for the full 256 steps
        program_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd255);
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'h0000_0001, 32'h0000_0000);

        // limit zero: a single step at most
        program_regs(32'h0000_0000, 32'h0000_0000, FOUR, 32'd0);
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(THREE, 32'h0000_0000);

        // random phases; upper bits of the radius and limit words carry junk
        // that the engine has to drop
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 4) < 3)
                radius_word = FOUR;
            else
                radius_word = {1'b0, 31'($urandom())};
            radius_word[31] = 1'($urandom());
            limit_word = {24'($urandom()), 8'($urandom_range(0, 100))};
            program_regs(pick_constant(), pick_constant(), radius_word, limit_word);
            steady = (phase == 4);      // one long stretch with no idle cycles
            n_items = 112;
            for (int k = 0; k < n_items; k++)
                send_pixel(pick_coord(), pick_coord());
            steady = 1'b0;
        end

        // deep phase: small c and the top limit, many orbits never escape
        program_regs($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                     $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                     FOUR, 32'd255);
        for (int k = 0; k < 40; k++)
            send_pixel(pick_coord(), pick_coord());

        // last setting puts the reset values back
        program_regs(jet_pkg::C_RE_RESET, jet_pkg::C_IM_RESET,
                     {1'b0, jet_pkg::RADIUS_RESET}, {24'd0, jet_pkg::ITER_LIMIT_RESET});
        for (int k = 0; k < 20; k++)
            send_pixel(pick_coord(), pick_coord());

        wait_idle();
        // watch for stray result beats after the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d pixels over %0d register settings plus reset values",
                 pixels_sent, settings_used);
        $display("compared %0d results, %0d mismatches, %0d still outstanding",
                 checked, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("julia_escape_time_test passed");
        end else begin
            $display("julia_escape_time_test failed");
        end
        $finish;
    end

endmodule
